// File: design/assert_macros.svh
// assertion helpers for the text address parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold on every clock edge out of reset
`define ITAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen out of reset
`define ITAP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ITAP_ASSERT(lbl, prop, msg)
`define ITAP_NEVER(lbl, cond, msg)
`endif

`endif

// File: design/itap_pkg.sv
package itap_pkg;

  localparam int ITAP_MAX_CHARS = 64;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [3:0] GROUPS_FULL = 4'd8;
  localparam logic [3:0] GROUPS_TAIL = 4'd6;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_HEX_FIRST,
    ACC_HEX_NEXT,
    ACC_DEC_FIRST,
    ACC_DEC_NEXT
  } acc_op_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FETCH,
    S_Q_START,
    S_Q_DIG,
    S_V6_START,
    S_V6_LEAD2,
    S_V6_GTOP,
    S_V6_GDIG,
    S_V6_COL,
    S_V6_END,
    S_ASM,
    S_DONE_OK,
    S_DONE_BAD
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    start;
    logic    adv;
    acc_op_e acc_op;
    logic    grp_store;
    logic    oct_store;
    logic    mark;
    logic    asm_step;
    logic    out_load;
    logic    out_ok;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ovf;
    logic colon;
    logic tail;
    logic is_dec;
    logic is_hex;
    logic is_colon;
    logic is_dot;
    logic lt_n;
    logic lt_stop;
    logic eq_stop;
    logic d_lt3;
    logic d_lt4;
    logic acc_gt255;
    logic k_last;
    logic heads_lt_maxg;
    logic heads_eq_maxg;
    logic marked;
    logic asm_last;
    logic out_free;
  } sts_t;

  function automatic logic char_is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic char_is_hex(input logic [7:0] c);
    return char_is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // nibble value of a hex or decimal digit
  function automatic logic [3:0] char_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (char_is_dec(c)) begin
      v = c[3:0];
    end else if (char_is_hex(c)) begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

endpackage

// File: design/itap_ctrl.sv
module itap_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_char_i,
  input  itap_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output itap_pkg::cmd_t cmd_o
);
  import itap_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.acc_op = ACC_NONE;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_char_i) begin
            state_d = sts_i.ovf ? S_DONE_BAD : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd_o.start = 1'b1;
        state_d = sts_i.colon ? S_V6_START : S_Q_START;
      end
      // dotted quad, one character a cycle
      S_Q_START: begin
        if (sts_i.lt_n && sts_i.is_dec) begin
          cmd_o.acc_op = ACC_DEC_FIRST;
          cmd_o.adv    = 1'b1;
          state_d      = S_Q_DIG;
        end else begin
          state_d = S_DONE_BAD;
        end
      end
      S_Q_DIG: begin
        if (sts_i.d_lt3 && sts_i.lt_n && sts_i.is_dec) begin
          cmd_o.acc_op = ACC_DEC_NEXT;
          cmd_o.adv    = 1'b1;
        end else if (sts_i.acc_gt255) begin
          state_d = S_DONE_BAD;
        end else begin
          cmd_o.oct_store = 1'b1;
          if (!sts_i.k_last) begin
            if (sts_i.lt_n && sts_i.is_dot) begin
              cmd_o.adv = 1'b1;
              state_d   = S_Q_START;
            end else begin
              state_d = S_DONE_BAD;
            end
          end else if (!sts_i.lt_n) begin
            state_d = sts_i.colon ? S_ASM : S_DONE_OK;
          end else begin
            state_d = S_DONE_BAD;
          end
        end
      end
      // leading compression
      S_V6_START: begin
        if (sts_i.lt_stop && sts_i.is_colon) begin
          cmd_o.adv = 1'b1;
          state_d   = S_V6_LEAD2;
        end else begin
          state_d = S_V6_GTOP;
        end
      end
      S_V6_LEAD2: begin
        if (sts_i.lt_stop && sts_i.is_colon) begin
          cmd_o.adv  = 1'b1;
          cmd_o.mark = 1'b1;
          state_d    = S_V6_GTOP;
        end else begin
          state_d = S_DONE_BAD;
        end
      end
      // hex groups
      S_V6_GTOP: begin
        if (sts_i.heads_lt_maxg && sts_i.lt_stop && sts_i.is_hex) begin
          cmd_o.acc_op = ACC_HEX_FIRST;
          cmd_o.adv    = 1'b1;
          state_d      = S_V6_GDIG;
        end else begin
          state_d = S_V6_END;
        end
      end
      S_V6_GDIG: begin
        if (sts_i.d_lt4 && sts_i.lt_stop && sts_i.is_hex) begin
          cmd_o.acc_op = ACC_HEX_NEXT;
          cmd_o.adv    = 1'b1;
        end else begin
          cmd_o.grp_store = 1'b1;
          if (sts_i.eq_stop) begin
            state_d = S_V6_END;
          end else if (!sts_i.is_colon) begin
            state_d = S_DONE_BAD;
          end else begin
            cmd_o.adv = 1'b1;
            state_d   = S_V6_COL;
          end
        end
      end
      S_V6_COL: begin
        if (!sts_i.lt_n) begin
          state_d = S_DONE_BAD;
        end else begin
          if (!sts_i.marked && sts_i.is_colon) begin
            cmd_o.adv  = 1'b1;
            cmd_o.mark = 1'b1;
          end
          state_d = S_V6_GTOP;
        end
      end
      S_V6_END: begin
        if (!sts_i.eq_stop) begin
          state_d = S_DONE_BAD;
        end else if (sts_i.marked ? !sts_i.heads_lt_maxg : !sts_i.heads_eq_maxg) begin
          state_d = S_DONE_BAD;
        end else begin
          state_d = sts_i.tail ? S_Q_START : S_ASM;
        end
      end
      // group expansion, one group a cycle
      S_ASM: begin
        cmd_o.asm_step = 1'b1;
        if (sts_i.asm_last) begin
          state_d = S_DONE_OK;
        end
      end
      S_DONE_OK, S_DONE_BAD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = (state_q == S_DONE_OK);
          state_d        = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// File: design/itap_dp.sv
module itap_dp #(
  parameter int MAX_CHARS = itap_pkg::ITAP_MAX_CHARS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     char_code_i,
  input  logic           out_ready_i,
  input  itap_pkg::cmd_t cmd_i,
  output itap_pkg::sts_t sts_o,
  output logic           out_valid_o,
  output logic           valid_res_o,
  output logic           is_v6_o,
  output logic [63:0]    addr_high_o,
  output logic [63:0]    addr_low_o
);
  import itap_pkg::*;

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int IW = $clog2(MAX_CHARS);
  localparam logic [PW-1:0] MAXC = PW'(MAX_CHARS);

  logic [7:0]    buf_mem [MAX_CHARS];
  logic [7:0]    rd_q;
  logic [PW-1:0] count_q, lastc_q, rp_q, rp_d, stop_n;
  logic          too_long_q, colon_q, dot_q;
  logic [15:0]   acc_q;
  logic [2:0]    dig_q;
  logic [1:0]    k_q;
  logic [3:0]    heads_q, cp_q;
  logic          marked_q;
  logic [15:0]   grp_q [8];
  logic [7:0]    oct_q [4];
  logic [2:0]    g_q;
  logic [127:0]  res_q;
  logic          room;
  logic [3:0]    nib, maxg, gap, g4, sel;
  logic          in_gap;
  logic [15:0]   gval;

  assign room   = count_q < MAXC;
  assign stop_n = dot_q ? PW'(lastc_q + 1'b1) : count_q;
  assign nib    = char_nibble(rd_q);

  // character buffer, read pointer follows next value
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      buf_mem[count_q[IW-1:0]] <= char_code_i;
    end
    rd_q <= buf_mem[rp_d[IW-1:0]];
  end

  always_comb begin
    rp_d = rp_q;
    if (cmd_i.start) begin
      rp_d = '0;
    end else if (cmd_i.adv) begin
      rp_d = PW'(rp_q + 1'b1);
    end
  end

  // string bookkeeping: count, colon and tail position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      too_long_q <= 1'b0;
      colon_q    <= 1'b0;
      dot_q      <= 1'b0;
      lastc_q    <= '0;
      rp_q       <= '0;
    end else begin
      rp_q <= rp_d;
      if (cmd_i.out_load) begin
        count_q    <= '0;
        too_long_q <= 1'b0;
        colon_q    <= 1'b0;
        dot_q      <= 1'b0;
      end else if (cmd_i.load) begin
        if (room) begin
          count_q <= PW'(count_q + 1'b1);
          if (char_code_i == CH_COLON) begin
            colon_q <= 1'b1;
            if (!dot_q) begin
              lastc_q <= count_q;
            end
          end else if (char_code_i == CH_DOT && colon_q) begin
            dot_q <= 1'b1;
          end
        end else begin
          too_long_q <= 1'b1;
        end
      end
    end
  end

  // parse counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_q    <= '0;
      k_q      <= '0;
      heads_q  <= '0;
      marked_q <= 1'b0;
      cp_q     <= '0;
      g_q      <= '0;
    end else begin
      if (cmd_i.start) begin
        k_q      <= '0;
        heads_q  <= '0;
        marked_q <= 1'b0;
        cp_q     <= '0;
        g_q      <= '0;
      end else begin
        if (cmd_i.oct_store) k_q <= k_q + 2'd1;
        if (cmd_i.grp_store) heads_q <= heads_q + 4'd1;
        if (cmd_i.mark) begin
          marked_q <= 1'b1;
          cp_q     <= heads_q;
        end
        if (cmd_i.asm_step) g_q <= g_q + 3'd1;
      end
      case (cmd_i.acc_op)
        ACC_HEX_FIRST, ACC_DEC_FIRST: dig_q <= 3'd1;
        ACC_HEX_NEXT, ACC_DEC_NEXT:   dig_q <= dig_q + 3'd1;
        default: ;
      endcase
    end
  end

  // value accumulator, groups and octets
  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_HEX_FIRST, ACC_DEC_FIRST: acc_q <= {12'd0, nib};
      ACC_HEX_NEXT: acc_q <= {acc_q[11:0], nib};
      ACC_DEC_NEXT: acc_q <= {acc_q[12:0], 3'd0} + {acc_q[14:0], 1'b0} + {12'd0, nib};
      default: ;
    endcase
    if (cmd_i.grp_store) grp_q[heads_q[2:0]] <= acc_q;
    if (cmd_i.oct_store) oct_q[k_q] <= acc_q[7:0];
    if (cmd_i.asm_step)  res_q <= {res_q[111:0], gval};
  end

  // group expansion around the compression gap
  always_comb begin
    maxg   = dot_q ? GROUPS_TAIL : GROUPS_FULL;
    gap    = maxg - heads_q;
    g4     = {1'b0, g_q};
    in_gap = marked_q && (g4 >= cp_q) && (g4 < cp_q + gap);
    sel    = (marked_q && (g4 >= cp_q + gap)) ? g4 - gap : g4;
    if (dot_q && (g4 >= GROUPS_TAIL)) begin
      gval = g_q[0] ? {oct_q[2], oct_q[3]} : {oct_q[0], oct_q[1]};
    end else if (in_gap) begin
      gval = '0;
    end else begin
      gval = grp_q[sel[2:0]];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      valid_res_o <= cmd_i.out_ok;
      is_v6_o     <= colon_q & ~too_long_q;
      if (cmd_i.out_ok && colon_q) begin
        addr_high_o <= res_q[127:64];
        addr_low_o  <= res_q[63:0];
      end else if (cmd_i.out_ok) begin
        addr_high_o <= '0;
        addr_low_o  <= {32'd0, oct_q[0], oct_q[1], oct_q[2], oct_q[3]};
      end else begin
        addr_high_o <= '0;
        addr_low_o  <= '0;
      end
    end
  end

  // status to controller
  always_comb begin
    sts_o.ovf           = too_long_q | ~room;
    sts_o.colon         = colon_q;
    sts_o.tail          = dot_q;
    sts_o.is_dec        = char_is_dec(rd_q);
    sts_o.is_hex        = char_is_hex(rd_q);
    sts_o.is_colon      = rd_q == CH_COLON;
    sts_o.is_dot        = rd_q == CH_DOT;
    sts_o.lt_n          = rp_q < count_q;
    sts_o.lt_stop       = rp_q < stop_n;
    sts_o.eq_stop       = rp_q == stop_n;
    sts_o.d_lt3         = dig_q < 3'd3;
    sts_o.d_lt4         = dig_q < 3'd4;
    sts_o.acc_gt255     = acc_q > 16'd255;
    sts_o.k_last        = k_q == 2'd3;
    sts_o.heads_lt_maxg = heads_q < maxg;
    sts_o.heads_eq_maxg = heads_q == maxg;
    sts_o.marked        = marked_q;
    sts_o.asm_last      = g_q == 3'd7;
    sts_o.out_free      = ~out_valid_o | out_ready_i;
  end

endmodule

// File: design/ip_text_address_parser_top.sv
// Text address parser: takes an IPv4 dotted or IPv6 colon address string one
// character a request (last_char_i marks the end) and returns one result per
// string: valid flag, family and the 128-bit address in network order. While
// loading, one character is taken per cycle into a MAX_CHARS byte buffer;
// extra characters are dropped and the string reported invalid. After the last
// character the buffer is re-read through its single read port at one character
// per cycle, except in the control states that read none: an IPv6 string passes
// through such a state on each single colon between groups, and its groups are
// then expanded one at a time around the compression.
// Input is taken again as soon as the result sits in the output register.
`include "assert_macros.svh"

module ip_text_address_parser_top #(
  parameter int MAX_CHARS = itap_pkg::ITAP_MAX_CHARS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic        is_v6_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o
);
  import itap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_char_i (last_char_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  itap_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_code_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .valid_res_o (valid_res_o),
    .is_v6_o     (is_v6_o),
    .addr_high_o (addr_high_o),
    .addr_low_o  (addr_low_o)
  );

  // checks
  `ITAP_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_o || out_ready_i), "result overwritten")
  `ITAP_NEVER(a_adv_in_load, cmd.adv && in_ready_o, "parse step during load")
  `ITAP_ASSERT(a_bad_zero, (out_valid_o && !valid_res_o) |-> (addr_high_o == 64'd0 && addr_low_o == 64'd0), "invalid result not zero")
  `ITAP_ASSERT(a_v4_high_zero, (out_valid_o && !is_v6_o) |-> (addr_high_o == 64'd0), "ipv4 high half not zero")

endmodule
